>>> hdl/icmp_reply_match_queue_top_assert.svh
// ----------------------------------------------------------------------------
// icmp_reply_match_queue_top_assert.svh
// Assertion macros for the reply match queue; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ICMP_REPLY_MATCH_QUEUE_TOP_ASSERT_SVH
`define ICMP_REPLY_MATCH_QUEUE_TOP_ASSERT_SVH

`ifndef SYNTH

// Check that prop holds at every clock edge outside reset.
`define IMRQ_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that expr is never true outside reset.
`define IMRQ_ASSERT_NEVER(lbl, clk, rst, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`else

`define IMRQ_ASSERT(lbl, clk, rst, prop, msg)

`define IMRQ_ASSERT_NEVER(lbl, clk, rst, expr, msg)

`endif

`endif

>>> hdl/imrq_pkg.sv
// ----------------------------------------------------------------------------
// imrq_pkg
// Shared types and constants of the reply match queue.
// ----------------------------------------------------------------------------
package imrq_pkg;

  localparam int QUEUE_SLOTS = 16;
  // One slot of the ring always stays empty, so the chain holds one less.
  localparam int CELLS = QUEUE_SLOTS - 1;

  localparam logic [1:0] MODE_PUSH = 2'd0;
  localparam logic [1:0] MODE_TAKE = 2'd1;
  localparam logic [1:0] MODE_SEND = 2'd2;

  localparam logic [1:0] STAT_ACCEPTED = 2'd0;
  localparam logic [1:0] STAT_MATCH    = 2'd1;
  localparam logic [1:0] STAT_NO_MATCH = 2'd2;

  typedef struct packed {
    logic [31:0] addr;
    logic [7:0]  kind;
    logic [7:0]  subcode;
    logic [15:0] ident;
    logic [15:0] seq;
    logic [7:0]  hops;
    logic [63:0] rtime;
  } rec_t;

  typedef struct packed {
    logic push;        // write a new record into the top cell
    logic shift;       // chain full: shift every cell down, drop the oldest
    logic scan_start;  // place the probe token on the oldest cell
    logic scan_step;   // probe the token cell, then advance the token
  } chain_ctl_t;

  typedef struct packed {
    logic settled;     // live records packed at the low end of the chain
    logic full;        // every cell holds a record
    logic hit;         // token cell holds a matching record
    logic miss;        // token ran past the last live record
  } chain_sts_t;

endpackage

>>> hdl/imrq_cell.sv
// ----------------------------------------------------------------------------
// imrq_cell
// One record cell: pulls from the cell above when empty or on a full shift.
// ----------------------------------------------------------------------------
module imrq_cell (
  input  logic          clk,
  input  logic          rst,
  input  imrq_pkg::rec_t up_rec,
  input  logic          up_valid,
  input  logic          dn_takes,
  input  logic          shift,
  input  logic          probe,
  input  logic [31:0]   key,
  output imrq_pkg::rec_t rec,
  output logic          valid,
  output logic          takes,
  output logic          match
);
  import imrq_pkg::*;

  assign takes = shift | ~valid;
  assign match = valid & ({rec.ident, rec.seq} == key);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (takes) begin
      valid <= up_valid;
    end else if (dn_takes || (probe && match)) begin
      // hand the record down, or drop it on a take hit
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (takes) begin
      rec <= up_rec;
    end
  end

endmodule

>>> hdl/imrq_chain.sv
// ----------------------------------------------------------------------------
// imrq_chain
// Row of record cells, oldest at cell 0, with a probe token for the search.
// ----------------------------------------------------------------------------
module imrq_chain (
  input  logic                 clk,
  input  logic                 rst,
  input  imrq_pkg::chain_ctl_t ctl,
  input  imrq_pkg::rec_t       new_rec,
  input  logic [31:0]          key,
  output imrq_pkg::chain_sts_t sts,
  output imrq_pkg::rec_t       sel_rec
);
  import imrq_pkg::*;

  rec_t             rec_q [CELLS];
  logic [CELLS-1:0] valid;
  logic [CELLS-1:0] takes;
  logic [CELLS-1:0] match;
  logic [CELLS-1:0] token;
  logic             settled;

  for (genvar i = 0; i < CELLS; i++) begin : g_cell
    rec_t up_rec;
    logic up_valid;
    logic dn_takes;

    if (i == CELLS - 1) begin : g_top
      assign up_rec   = new_rec;
      assign up_valid = ctl.push;
    end else begin : g_mid
      assign up_rec   = rec_q[i+1];
      assign up_valid = valid[i+1];
    end

    if (i == 0) begin : g_bot
      assign dn_takes = 1'b0;
    end else begin : g_upper
      assign dn_takes = takes[i-1];
    end

    imrq_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .up_rec   (up_rec),
      .up_valid (up_valid),
      .dn_takes (dn_takes),
      .shift    (ctl.shift),
      .probe    (ctl.scan_step & token[i]),
      .key      (key),
      .rec      (rec_q[i]),
      .valid    (valid[i]),
      .takes    (takes[i]),
      .match    (match[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      token <= '0;
    end else if (ctl.scan_start) begin
      token <= CELLS'(1);
    end else if (ctl.scan_step) begin
      token <= token << 1;
    end
  end

  // Packed when no empty cell sits below a live one.
  always_comb begin
    settled = 1'b1;
    for (int i = 0; i < CELLS - 1; i++) begin
      if (!valid[i] && valid[i+1]) begin
        settled = 1'b0;
      end
    end
  end

  always_comb begin
    sel_rec = '0;
    for (int i = 0; i < CELLS; i++) begin
      if (token[i]) begin
        sel_rec = rec_q[i];
      end
    end
  end

  assign sts.settled = settled;
  assign sts.full    = settled & valid[CELLS-1];
  assign sts.hit     = |(token & match);
  assign sts.miss    = ~(|token) | (|(token & ~valid));

endmodule

>>> hdl/icmp_reply_match_queue_top.sv
// ----------------------------------------------------------------------------
// icmp_reply_match_queue_top
// Queue of received ICMP reply records with keyed removal and RTT report.
// ----------------------------------------------------------------------------
// Sequence: a push or send-time word passes to DONE and then to the output
// register; a take walks the token through SCAN from the oldest record, then
// goes through CALC on a hit, or straight to DONE on no match.
// Throughput: one word at a time; after a push or a hit the chain re-packs one
// cell per cycle, and the next word waits until the chain is packed.
// Reset: synchronous, active high; empties the chain and zeroes the send time.
// ----------------------------------------------------------------------------
`include "icmp_reply_match_queue_top_assert.svh"

module icmp_reply_match_queue_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  mode,
  input  logic [31:0] peer_addr,
  input  logic [7:0]  msg_kind,
  input  logic [7:0]  msg_subcode,
  input  logic [15:0] ident,
  input  logic [15:0] sequence_req,
  input  logic [7:0]  hop_limit,
  input  logic [63:0] time_us,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [31:0] out_addr,
  output logic [7:0]  out_kind,
  output logic [7:0]  out_subcode,
  output logic [15:0] out_sequence,
  output logic [7:0]  out_hop_limit,
  output logic [63:0] round_trip_us
);
  import imrq_pkg::*;

  typedef enum logic [1:0] {
    IDLE,   // wait for a word and a packed chain
    SCAN,   // walk the token from the oldest record upward
    CALC,   // form the round-trip time of the hit
    DONE    // hand the result to the output register
  } state_t;

  state_t     state;
  chain_ctl_t ctl;
  chain_sts_t sts;
  rec_t       new_rec;
  rec_t       sel_rec;
  logic       accept;

  // Held result, waiting for the output register.
  logic [1:0]  res_status;
  logic [31:0] res_addr;
  logic [7:0]  res_kind;
  logic [7:0]  res_subcode;
  logic [15:0] res_sequence;
  logic [7:0]  res_hops;
  logic [63:0] res_rtt;
  logic [63:0] hit_time;
  logic [63:0] send_time;
  // Search key of the take, held for the whole scan.
  logic [31:0] take_key;

  // Accept only on a packed chain: a push needs the top cell free.
  assign in_ready = (state == IDLE) && sts.settled;
  assign accept   = in_valid && in_ready;

  assign new_rec.addr    = peer_addr;
  assign new_rec.kind    = msg_kind;
  assign new_rec.subcode = msg_subcode;
  assign new_rec.ident   = ident;
  assign new_rec.seq     = sequence_req;
  assign new_rec.hops    = hop_limit;
  assign new_rec.rtime   = time_us;

  // A push into a full chain shifts every cell down and drops the oldest.
  assign ctl.push       = accept && (mode == MODE_PUSH);
  assign ctl.shift      = ctl.push && sts.full;
  assign ctl.scan_start = accept && (mode == MODE_TAKE);
  assign ctl.scan_step  = (state == SCAN);

  imrq_chain u_chain (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .new_rec (new_rec),
    .key     (take_key),
    .sts     (sts),
    .sel_rec (sel_rec)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
      send_time <= '0;
    end else begin
      // Drop the word once taken, unless a new one loads at this edge.
      if (out_ready && (state != DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (accept) begin
            // Every result but a hit carries zero fields.
            res_status   <= STAT_ACCEPTED;
            res_addr     <= '0;
            res_kind     <= '0;
            res_subcode  <= '0;
            res_sequence <= '0;
            res_hops     <= '0;
            res_rtt      <= '0;
            take_key     <= {ident, sequence_req};
            case (mode)
              MODE_TAKE: begin
                state <= SCAN;
              end
              MODE_SEND: begin
                send_time <= time_us;
                state     <= DONE;
              end
              default: begin
                state <= DONE;
              end
            endcase
          end
        end
        SCAN: begin
          if (sts.hit) begin
            // The cell drops the record at this edge; the chain re-packs.
            res_status   <= STAT_MATCH;
            res_addr     <= sel_rec.addr;
            res_kind     <= sel_rec.kind;
            res_subcode  <= sel_rec.subcode;
            res_sequence <= sel_rec.seq;
            res_hops     <= sel_rec.hops;
            hit_time     <= sel_rec.rtime;
            state        <= CALC;
          end else if (sts.miss) begin
            res_status <= STAT_NO_MATCH;
            state      <= DONE;
          end
        end
        CALC: begin
          res_rtt <= (hit_time > send_time) ? (hit_time - send_time) : '0;
          state   <= DONE;
        end
        DONE: begin
          if (!out_valid || out_ready) begin
            status        <= res_status;
            out_addr      <= res_addr;
            out_kind      <= res_kind;
            out_subcode   <= res_subcode;
            out_sequence  <= res_sequence;
            out_hop_limit <= res_hops;
            round_trip_us <= res_rtt;
            out_valid     <= 1'b1;
            state         <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  // The token walk relies on a packed chain: nothing may move during a scan.
  `IMRQ_ASSERT(a_scan_packed, clk, rst, (state == SCAN) |-> sts.settled, "chain moved during scan")
  // A hit and a no-match status never come from the same probe.
  `IMRQ_ASSERT(a_hit_first, clk, rst, (state == SCAN) && sts.hit |=> (state == CALC), "hit not taken")
  // Only a hit carries record fields.
  `IMRQ_ASSERT(a_zero_fields, clk, rst, out_valid && (status != STAT_MATCH) |-> (out_addr == '0) && (round_trip_us == '0), "fields set without hit")
  // The status code is one of the three defined ones.
  `IMRQ_ASSERT_NEVER(a_status_code, clk, rst, out_valid && (status == 2'd3), "undefined status")

endmodule

>>> sim/imrq_tb_pkg.sv
// ----------------------------------------------------------------------------
// imrq_tb_pkg
// Expected-reply scoreboard for the reply match queue bench: keeps its own
// ordered list of held reply records and the send time, and compares words.
// ----------------------------------------------------------------------------
package imrq_tb_pkg;

  import imrq_pkg::*;

  // One word on the result side of the block.
  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] addr;
    logic [7:0]  kind;
    logic [7:0]  subcode;
    logic [15:0] seq;
    logic [7:0]  hops;
    logic [63:0] rtt;
  } reply_t;

  class reply_match_scoreboard;

    rec_t        held[$];   // live records, oldest first
    logic [63:0] send_time;
    reply_t      due[$];    // expected replies, oldest first
    int errors, words, pushes, hits, misses, drops, sends;

    function new();
      send_time = '0;
      errors = 0;
      words = 0;
      pushes = 0;
      hits = 0;
      misses = 0;
      drops = 0;
      sends = 0;
    endfunction

    // Apply one accepted input word and queue the reply it must produce.
    function void note_word(logic [1:0] mode, rec_t w);
      reply_t r;
      int idx;
      r = '0;
      r.status = STAT_ACCEPTED;
      idx = -1;
      words++;
      case (mode)
        MODE_PUSH: begin
          if (held.size() == CELLS) begin
            void'(held.pop_front());
            drops++;
          end
          held.push_back(w);
          pushes++;
        end
        MODE_TAKE: begin
          foreach (held[i])
            if (idx < 0 && held[i].ident == w.ident && held[i].seq == w.seq)
              idx = i;
          if (idx < 0) begin
            r.status = STAT_NO_MATCH;
            misses++;
          end else begin
            r.status  = STAT_MATCH;
            r.addr    = held[idx].addr;
            r.kind    = held[idx].kind;
            r.subcode = held[idx].subcode;
            r.seq     = held[idx].seq;
            r.hops    = held[idx].hops;
            r.rtt     = (held[idx].rtime > send_time) ? held[idx].rtime - send_time : '0;
            held.delete(idx);
            hits++;
          end
        end
        MODE_SEND: begin
          send_time = w.rtime;
          sends++;
        end
        default: ;
      endcase
      due.push_back(r);
    endfunction

    task report(string msg);
      errors++;
      $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // Compare one accepted reply word against the oldest expectation.
    task check_reply(reply_t got);
      reply_t want;
      if (due.size() == 0) begin
        report($sformatf("reply word with none expected, status %0d", got.status));
        return;
      end
      want = due.pop_front();
      if (got.status !== want.status)
        report($sformatf("status got %0h want %0h", got.status, want.status));
      if (got.addr !== want.addr)
        report($sformatf("out_addr got %0h want %0h", got.addr, want.addr));
      if (got.kind !== want.kind)
        report($sformatf("out_kind got %0h want %0h", got.kind, want.kind));
      if (got.subcode !== want.subcode)
        report($sformatf("out_subcode got %0h want %0h", got.subcode, want.subcode));
      if (got.seq !== want.seq)
        report($sformatf("out_sequence got %0h want %0h", got.seq, want.seq));
      if (got.hops !== want.hops)
        report($sformatf("out_hop_limit got %0h want %0h", got.hops, want.hops));
      if (got.rtt !== want.rtt)
        report($sformatf("round_trip_us got %0h want %0h", got.rtt, want.rtt));
    endtask

  endclass

endpackage

>>> sim/tb_icmp_reply_match_queue_top.sv
// ----------------------------------------------------------------------------
// tb_icmp_reply_match_queue_top
// Self-checking bench for the reply match queue: a directed opening covers
// field extremes, overflow, keyed removal from the middle and round-trip
// clamping, then random push/take/send traffic with random idling on both
// sides, a long receiver stall and a full drain pause.
// ----------------------------------------------------------------------------
module tb_icmp_reply_match_queue_top;

  timeunit 1ns;
  timeprecision 1ps;

  import imrq_pkg::*;
  import imrq_tb_pkg::*;

  localparam int         CLK_HALF     = 5;
  localparam int         RESET_CYCLES = 4;
  localparam int         RANDOM_WORDS = 1300;
  localparam int         LONG_HOLD    = 300;     // receiver stall, in cycles
  localparam int         DRAIN_CYCLES = 40;      // > worst take plus re-pack
  localparam int         CYCLE_LIMIT  = 400000;
  localparam logic [1:0] MODE_UNUSED  = 2'd3;    // block must ignore this mode

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  mode = MODE_PUSH;
  logic [31:0] peer_addr = '0;
  logic [7:0]  msg_kind = '0;
  logic [7:0]  msg_subcode = '0;
  logic [15:0] ident = '0;
  logic [15:0] sequence_req = '0;
  logic [7:0]  hop_limit = '0;
  logic [63:0] time_us = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  status;
  logic [31:0] out_addr;
  logic [7:0]  out_kind;
  logic [7:0]  out_subcode;
  logic [15:0] out_sequence;
  logic [7:0]  out_hop_limit;
  logic [63:0] round_trip_us;

  // Idling controls, changed by the stimulus between phases.
  bit send_idle = 1'b1;
  bit recv_idle = 1'b1;
  bit long_hold_req = 1'b0;
  int push_pct = 45;
  int cycle_count = 0;

  reply_match_scoreboard sb = new();

  icmp_reply_match_queue_top dut (.*);

  always #CLK_HALF clk = ~clk;

  // Watchdog: end the run if the traffic never completes.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Check every reply word accepted at this edge.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_reply(reply_t'{status, out_addr, out_kind, out_subcode, out_sequence,
                              out_hop_limit, round_trip_us});
  end

  // Receiver: draw a stall per word; on request, hold off for a long stretch
  // so the block backs up and stalls its input.
  initial begin
    int hold;
    while (rst) @(posedge clk);
    forever begin
      hold = recv_idle ? $urandom_range(0, 9) : 0;
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold += LONG_HOLD;
      end
      if (hold > 0) begin
        out_ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // Offer one input word after a random gap; hold it until accepted, then
  // record it with the scoreboard.
  task automatic put_word(input logic [1:0] m, input rec_t w);
    int gap;
    gap = send_idle ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    mode         <= m;
    peer_addr    <= w.addr;
    msg_kind     <= w.kind;
    msg_subcode  <= w.subcode;
    ident        <= w.ident;
    sequence_req <= w.seq;
    hop_limit    <= w.hops;
    time_us      <= w.rtime;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_word(m, w);
  endtask

  function automatic rec_t mk_rec(logic [31:0] addr, logic [7:0] kind, logic [7:0] subcode,
                                  logic [15:0] id, logic [15:0] seq, logic [7:0] hops,
                                  logic [63:0] t);
    rec_t w;
    w = '{addr, kind, subcode, id, seq, hops, t};
    return w;
  endfunction

  // Random record; keep most keys in a narrow space so takes hit and
  // duplicate keys occur, and most times near the send time so the
  // round trip lands on both sides of zero.
  function automatic rec_t rand_rec();
    rec_t w;
    w.addr    = $urandom;
    w.kind    = 8'($urandom);
    w.subcode = 8'($urandom);
    w.ident   = ($urandom_range(0, 3) != 0) ? 16'($urandom_range(0, 3)) : 16'($urandom);
    w.seq     = ($urandom_range(0, 3) != 0) ? 16'($urandom_range(0, 15)) : 16'($urandom);
    w.hops    = 8'($urandom);
    if ($urandom_range(0, 1) != 0)
      w.rtime = sb.send_time + 64'($urandom_range(0, 4000)) - 64'd2000;
    else
      w.rtime = {$urandom, $urandom};
    return w;
  endfunction

  task automatic rand_word();
    rec_t w;
    rec_t pick;
    logic [1:0] m;
    int r;
    w = rand_rec();
    r = $urandom_range(0, 99);
    if (r < push_pct) begin
      m = MODE_PUSH;
    end else if (r < 90) begin
      m = MODE_TAKE;
      // Mostly ask for a key that is held, so removal gets exercised.
      if (sb.held.size() > 0 && $urandom_range(0, 3) != 0) begin
        pick = sb.held[$urandom_range(0, sb.held.size() - 1)];
        w.ident = pick.ident;
        w.seq = pick.seq;
      end
    end else if (r < 97) begin
      m = MODE_SEND;
    end else begin
      m = MODE_UNUSED;
    end
    put_word(m, w);
  endtask

  initial begin
    int phase;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Directed opening: take on an empty queue, ignored mode, all-ones and
    // all-zeros records, round trip at its extremes.
    put_word(MODE_TAKE, mk_rec('1, '1, '1, '1, '1, '1, '1));
    put_word(MODE_UNUSED, mk_rec('1, '1, '1, '1, '1, '1, '1));
    put_word(MODE_SEND, mk_rec('0, '0, '0, '0, '0, '0, '0));
    put_word(MODE_PUSH, mk_rec('1, '1, '1, '1, '1, '1, '1));
    put_word(MODE_PUSH, mk_rec('0, '0, '0, '0, '0, '0, '0));
    put_word(MODE_TAKE, mk_rec('0, '0, '0, '1, '1, '0, '0));
    put_word(MODE_SEND, mk_rec('0, '0, '0, '0, '0, '0, '1));
    // Receive time earlier than send time: round trip clamps to zero.
    put_word(MODE_TAKE, mk_rec('1, '1, '1, '0, '0, '1, '1));

    // Overfill the queue so the oldest record drops, then take the dropped
    // key, a middle record whose receive time equals the send time, and
    // the newest record.
    put_word(MODE_SEND, mk_rec('0, '0, '0, '0, '0, '0, 64'd1000));
    for (int i = 0; i < CELLS + 1; i++)
      put_word(MODE_PUSH, mk_rec(32'hC0A8_0000 + i, 8'd0, 8'(i), 16'h0100, 16'(i),
                                 8'(64 - i), 64'd990 + i));
    put_word(MODE_TAKE, mk_rec('0, '0, '0, 16'h0100, 16'd0, '0, '0));
    put_word(MODE_TAKE, mk_rec('0, '0, '0, 16'h0100, 16'd10, '0, '0));
    put_word(MODE_TAKE, mk_rec('0, '0, '0, 16'h0100, 16'd15, '0, '0));

    // Random traffic in phases: alternate idling on each side, switch the
    // push share so the queue both fills and empties.
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n % 100 == 0) begin
        phase = n / 100;
        send_idle = (phase % 3 != 1);
        recv_idle = (phase % 3 != 2);
        push_pct = (phase % 2 != 0) ? 70 : 45;
      end
      // Stall the receiver while the sender keeps offering words.
      if (n == 400)
        long_hold_req = 1'b1;
      // Pause the sender until every outstanding reply is back.
      if (n == 800) begin
        in_valid <= 1'b0;
        do @(posedge clk); while (sb.due.size() != 0);
      end
      rand_word();
    end
    in_valid <= 1'b0;

    // Drain: wait for the last reply, then watch for stray words.
    while (sb.due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d words: %0d pushes (%0d overflow drops), %0d sends,",
             sb.words, sb.pushes, sb.drops, sb.sends);
    $display("  %0d takes matched and %0d missed; %0d mismatches.",
             sb.hits, sb.misses, sb.errors);
    if (sb.errors == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
